// File: sv/cdu_pkg.sv
// shared types, constants and calendar tables for the calendar date unit
`timescale 1ns / 1ps

package cdu_pkg;

  // field widths fixed by the interface
  localparam int DAY_W   = 5;
  localparam int MON_W   = 4;
  localparam int DDIFF_W = 22;
  localparam int MDIFF_W = 17;

  localparam logic [MON_W-1:0] FIRST_MONTH = 4'd0;
  localparam logic [MON_W-1:0] LAST_MONTH  = 4'd11;
  localparam logic [DAY_W-1:0] FIRST_DAY   = 5'd1;
  localparam int               RESET_YEAR  = 2000;

  // operation codes
  typedef enum logic [2:0] {
    FUNC_LOAD       = 3'd0,
    FUNC_ADD_DAYS   = 3'd1,
    FUNC_NEXT_DAY   = 3'd2,
    FUNC_PREV_DAY   = 3'd3,
    FUNC_NEXT_MONTH = 3'd4,
    FUNC_DAY_DIFF   = 3'd5,
    FUNC_MONTH_DIFF = 3'd6
  } func_e;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_ADDC,
    ST_WALK,
    ST_DSTEP,
    ST_MSTEP,
    ST_MDEC,
    ST_FIN
  } state_e;

  // accumulator operations
  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD
  } acc_op_e;

  // operand choices for the shared adder
  typedef enum logic [3:0] {
    TERM_Y0,
    TERM_Y2,
    TERM_Y3,
    TERM_Y5,
    TERM_Y6,
    TERM_Y8,
    TERM_QUAD,
    TERM_SMALL,
    TERM_MON,
    TERM_ONE,
    TERM_COUNT,
    TERM_DAY,
    TERM_DIM
  } term_e;

  // commands from the sequencer to the datapath
  typedef struct packed {
    logic    in_load;
    func_e   func;
    acc_op_e acc_op;
    term_e   term;
    logic    term_other;
    logic    term_sub;
    logic    simple_exec;
    logic    walk_adv;
    logic    walk_fin;
    logic    out_load;
  } ctl_t;

  // status from the datapath to the sequencer
  typedef struct packed {
    logic earlier;
    logic walk_more;
    logic mdec_need;
  } sts_t;

  // length of a month, months above december read as december
  function automatic logic [DAY_W-1:0] days_in(logic [MON_W-1:0] m, logic leap);
    logic [DAY_W-1:0] len;
    case (m) inside
      4'd1:                    len = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10: len = 5'd30;
      default:                 len = 5'd31;
    endcase
    return len;
  endfunction

  // days before the first of a month in a common year
  function automatic logic [8:0] month_start(logic [MON_W-1:0] m);
    logic [8:0] s;
    case (m)
      4'd0:    s = 9'd0;
      4'd1:    s = 9'd31;
      4'd2:    s = 9'd59;
      4'd3:    s = 9'd90;
      4'd4:    s = 9'd120;
      4'd5:    s = 9'd151;
      4'd6:    s = 9'd181;
      4'd7:    s = 9'd212;
      4'd8:    s = 9'd243;
      4'd9:    s = 9'd273;
      4'd10:   s = 9'd304;
      4'd11:   s = 9'd334;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

  // terms of a day number: 365 * year in shifted parts, leap days, the rest
  function automatic term_e dn_term(logic [2:0] idx);
    term_e t;
    case (idx)
      3'd0:    t = TERM_Y0;
      3'd1:    t = TERM_Y2;
      3'd2:    t = TERM_Y3;
      3'd3:    t = TERM_Y5;
      3'd4:    t = TERM_Y6;
      3'd5:    t = TERM_Y8;
      3'd6:    t = TERM_QUAD;
      default: t = TERM_SMALL;
    endcase
    return t;
  endfunction

endpackage

// File: sv/cdu_ctrl.sv
// sequencer that steps the shared adder through each operation
`timescale 1ns / 1ps

module cdu_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [2:0]    func_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  cdu_pkg::sts_t sts_i,
  output cdu_pkg::ctl_t ctl_o
);

  localparam logic [3:0] DSTEP_LAST = 4'd15;
  localparam logic [3:0] MSTEP_LAST = 4'd5;

  cdu_pkg::state_e state_q, state_d;
  cdu_pkg::func_e  func_q;
  logic [3:0]      step_q, step_d;
  logic            out_valid_q;
  logic            accept;
  logic            slot_free;

  assign in_ready_o  = (state_q == cdu_pkg::ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign slot_free   = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  // next state and step count
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    unique case (state_q)
      cdu_pkg::ST_IDLE: begin
        if (accept) state_d = cdu_pkg::ST_EXEC;
      end
      cdu_pkg::ST_EXEC: begin
        step_d = 4'd1;
        unique case (func_q)
          cdu_pkg::FUNC_ADD_DAYS:   state_d = cdu_pkg::ST_ADDC;
          cdu_pkg::FUNC_DAY_DIFF:   state_d = sts_i.earlier ? cdu_pkg::ST_FIN : cdu_pkg::ST_DSTEP;
          cdu_pkg::FUNC_MONTH_DIFF: state_d = sts_i.earlier ? cdu_pkg::ST_FIN : cdu_pkg::ST_MSTEP;
          default:                  state_d = cdu_pkg::ST_FIN;
        endcase
      end
      cdu_pkg::ST_ADDC: state_d = cdu_pkg::ST_WALK;
      cdu_pkg::ST_WALK: begin
        if (!sts_i.walk_more) state_d = cdu_pkg::ST_FIN;
      end
      cdu_pkg::ST_DSTEP: begin
        step_d = step_q + 4'd1;
        if (step_q == DSTEP_LAST) state_d = cdu_pkg::ST_FIN;
      end
      cdu_pkg::ST_MSTEP: begin
        step_d = step_q + 4'd1;
        if (step_q == MSTEP_LAST) state_d = cdu_pkg::ST_MDEC;
      end
      cdu_pkg::ST_MDEC: state_d = cdu_pkg::ST_FIN;
      cdu_pkg::ST_FIN: begin
        if (slot_free) state_d = cdu_pkg::ST_IDLE;
      end
      default: state_d = cdu_pkg::ST_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    ctl_o             = '0;
    ctl_o.func        = func_q;
    ctl_o.acc_op      = cdu_pkg::ACC_HOLD;
    ctl_o.term        = cdu_pkg::TERM_Y0;
    unique case (state_q)
      cdu_pkg::ST_IDLE: ctl_o.in_load = accept;
      cdu_pkg::ST_EXEC: begin
        unique case (func_q)
          cdu_pkg::FUNC_ADD_DAYS: begin
            ctl_o.acc_op = cdu_pkg::ACC_LOAD;
            ctl_o.term   = cdu_pkg::TERM_DAY;
          end
          cdu_pkg::FUNC_DAY_DIFF: begin
            if (!sts_i.earlier) ctl_o.acc_op = cdu_pkg::ACC_LOAD;
            ctl_o.term = cdu_pkg::TERM_Y0;
          end
          cdu_pkg::FUNC_MONTH_DIFF: begin
            if (!sts_i.earlier) ctl_o.acc_op = cdu_pkg::ACC_LOAD;
            ctl_o.term = cdu_pkg::TERM_Y3;
          end
          default: ctl_o.simple_exec = 1'b1;
        endcase
      end
      cdu_pkg::ST_ADDC: begin
        ctl_o.acc_op = cdu_pkg::ACC_ADD;
        ctl_o.term   = cdu_pkg::TERM_COUNT;
      end
      cdu_pkg::ST_WALK: begin
        // trial subtract of the month length decides another month
        ctl_o.term     = cdu_pkg::TERM_DIM;
        ctl_o.term_sub = 1'b1;
        if (sts_i.walk_more) begin
          ctl_o.acc_op   = cdu_pkg::ACC_ADD;
          ctl_o.walk_adv = 1'b1;
        end else begin
          ctl_o.walk_fin = 1'b1;
        end
      end
      cdu_pkg::ST_DSTEP: begin
        // first half adds the stored day number, second half subtracts the other
        ctl_o.acc_op     = cdu_pkg::ACC_ADD;
        ctl_o.term       = cdu_pkg::dn_term(step_q[2:0]);
        ctl_o.term_other = step_q[3];
        ctl_o.term_sub   = step_q[3];
      end
      cdu_pkg::ST_MSTEP: begin
        ctl_o.acc_op = cdu_pkg::ACC_ADD;
        case (step_q)
          4'd1: ctl_o.term = cdu_pkg::TERM_Y2;
          4'd2: ctl_o.term = cdu_pkg::TERM_MON;
          4'd3: begin
            ctl_o.term       = cdu_pkg::TERM_Y3;
            ctl_o.term_other = 1'b1;
            ctl_o.term_sub   = 1'b1;
          end
          4'd4: begin
            ctl_o.term       = cdu_pkg::TERM_Y2;
            ctl_o.term_other = 1'b1;
            ctl_o.term_sub   = 1'b1;
          end
          default: begin
            ctl_o.term       = cdu_pkg::TERM_MON;
            ctl_o.term_other = 1'b1;
            ctl_o.term_sub   = 1'b1;
          end
        endcase
      end
      cdu_pkg::ST_MDEC: begin
        // partial last month does not count
        ctl_o.term     = cdu_pkg::TERM_ONE;
        ctl_o.term_sub = 1'b1;
        if (sts_i.mdec_need) ctl_o.acc_op = cdu_pkg::ACC_ADD;
      end
      cdu_pkg::ST_FIN: ctl_o.out_load = slot_free;
      default: ctl_o.acc_op = cdu_pkg::ACC_HOLD;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cdu_pkg::ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      if (ctl_o.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // operation code of the beat in work
  always_ff @(posedge clk_i) begin
    if (accept) func_q <= cdu_pkg::func_e'(func_i);
  end

endmodule

// File: sv/cdu_datapath.sv
// date registers, shared adder with accumulator, and result registers
`timescale 1ns / 1ps

module cdu_datapath #(
  parameter int YEAR_BITS  = 12,
  parameter int COUNT_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  cdu_pkg::ctl_t                      ctl_i,
  output cdu_pkg::sts_t                      sts_o,
  input  logic [COUNT_BITS-1:0]              day_count_i,
  input  logic [cdu_pkg::DAY_W-1:0]          other_day_i,
  input  logic [cdu_pkg::MON_W-1:0]          other_month_i,
  input  logic [YEAR_BITS-1:0]               other_year_i,
  output logic [cdu_pkg::DAY_W-1:0]          cur_day_o,
  output logic [cdu_pkg::MON_W-1:0]          cur_month_o,
  output logic [YEAR_BITS-1:0]               cur_year_o,
  output logic                               before_other_o,
  output logic                               equals_other_o,
  output logic                               after_other_o,
  output logic signed [cdu_pkg::DDIFF_W-1:0] day_difference_o,
  output logic signed [cdu_pkg::MDIFF_W-1:0] month_difference_o,
  output logic                               year_overflow_o
);

  localparam int DnW  = YEAR_BITS + 10;
  localparam int CntW = COUNT_BITS + 2;
  localparam int WideW = (DnW > CntW) ? DnW : CntW;
  localparam int AccW = (WideW > cdu_pkg::DDIFF_W) ? WideW : cdu_pkg::DDIFF_W;

  // stored date
  logic [cdu_pkg::DAY_W-1:0] day_q, day_d;
  logic [cdu_pkg::MON_W-1:0] mon_q, mon_d;
  logic [YEAR_BITS-1:0]      yr_q, yr_d;
  logic                      ovf_q, ovf_d;

  // beat under work
  logic [cdu_pkg::DAY_W-1:0] od_q;
  logic [cdu_pkg::MON_W-1:0] om_q;
  logic [YEAR_BITS-1:0]      oy_q;
  logic [COUNT_BITS-1:0]     cnt_q;
  logic [AccW-1:0]           acc_q;

  // result registers
  logic [cdu_pkg::DAY_W-1:0]          out_day_q;
  logic [cdu_pkg::MON_W-1:0]          out_mon_q;
  logic [YEAR_BITS-1:0]               out_yr_q;
  logic                               out_before_q, out_equal_q, out_after_q, out_ovf_q;
  logic signed [cdu_pkg::DDIFF_W-1:0] out_ddiff_q;
  logic signed [cdu_pkg::MDIFF_W-1:0] out_mdiff_q;

  // other date made valid
  logic [cdu_pkg::MON_W-1:0] om_c;
  logic [cdu_pkg::DAY_W-1:0] dim_in, od_c;

  assign om_c   = (other_month_i > cdu_pkg::LAST_MONTH) ? cdu_pkg::LAST_MONTH : other_month_i;
  assign dim_in = cdu_pkg::days_in(om_c, other_year_i[1:0] == 2'b00);
  assign od_c   = (other_day_i == '0) ? cdu_pkg::FIRST_DAY :
                  ((other_day_i > dim_in) ? dim_in : other_day_i);

  always_ff @(posedge clk_i) begin
    if (ctl_i.in_load) begin
      od_q  <= od_c;
      om_q  <= om_c;
      oy_q  <= other_year_i;
      cnt_q <= day_count_i;
    end
  end

  // month arithmetic on the stored date
  logic [cdu_pkg::DAY_W-1:0] cur_dim, adv_dim;
  logic                      adv_wrap, adv_ovf;
  logic [cdu_pkg::MON_W-1:0] adv_mon, prev_mon;
  logic [YEAR_BITS-1:0]      adv_yr, prev_yr;

  assign cur_dim  = cdu_pkg::days_in(mon_q, yr_q[1:0] == 2'b00);
  assign adv_wrap = (mon_q == cdu_pkg::LAST_MONTH);
  assign adv_mon  = adv_wrap ? cdu_pkg::FIRST_MONTH : mon_q + 4'd1;
  assign adv_yr   = adv_wrap ? yr_q + YEAR_BITS'(1) : yr_q;
  assign adv_ovf  = adv_wrap && (&yr_q);
  assign adv_dim  = cdu_pkg::days_in(adv_mon, adv_yr[1:0] == 2'b00);
  assign prev_mon = mon_q - 4'd1;
  assign prev_yr  = yr_q - YEAR_BITS'(1);

  // operand selection for the shared adder
  logic [YEAR_BITS-1:0]      tx_yr;
  logic [cdu_pkg::MON_W-1:0] tx_mon;
  logic [cdu_pkg::DAY_W-1:0] tx_day;
  logic                      tx_adj;
  logic [YEAR_BITS:0]        tx_yr3;
  logic [AccW-1:0]           tx_y, term_val, opnd, sum;
  logic                      carry;

  assign tx_yr  = ctl_i.term_other ? oy_q : yr_q;
  assign tx_mon = ctl_i.term_other ? om_q : mon_q;
  assign tx_day = ctl_i.term_other ? od_q : day_q;
  assign tx_adj = (tx_mon > 4'd1) && (tx_yr[1:0] == 2'b00);
  assign tx_yr3 = {1'b0, tx_yr} + (YEAR_BITS + 1)'(3);
  assign tx_y   = AccW'(tx_yr);

  always_comb begin
    case (ctl_i.term)
      cdu_pkg::TERM_Y0:    term_val = tx_y;
      cdu_pkg::TERM_Y2:    term_val = tx_y << 2;
      cdu_pkg::TERM_Y3:    term_val = tx_y << 3;
      cdu_pkg::TERM_Y5:    term_val = tx_y << 5;
      cdu_pkg::TERM_Y6:    term_val = tx_y << 6;
      cdu_pkg::TERM_Y8:    term_val = tx_y << 8;
      cdu_pkg::TERM_QUAD:  term_val = AccW'(tx_yr3 >> 2);
      cdu_pkg::TERM_SMALL: term_val = AccW'(cdu_pkg::month_start(tx_mon)) + AccW'(tx_adj)
                                      + AccW'(tx_day);
      cdu_pkg::TERM_MON:   term_val = AccW'(tx_mon);
      cdu_pkg::TERM_ONE:   term_val = AccW'(1);
      cdu_pkg::TERM_COUNT: term_val = AccW'(cnt_q);
      cdu_pkg::TERM_DAY:   term_val = AccW'(day_q);
      cdu_pkg::TERM_DIM:   term_val = AccW'(cur_dim);
      default:             term_val = '0;
    endcase
  end

  // shared add and subtract unit, carry out high means no borrow
  assign opnd = ctl_i.term_sub ? ~term_val : term_val;
  assign {carry, sum} = {1'b0, acc_q} + {1'b0, opnd} + (AccW + 1)'(ctl_i.term_sub);

  always_ff @(posedge clk_i) begin
    case (ctl_i.acc_op)
      cdu_pkg::ACC_LOAD: acc_q <= term_val;
      cdu_pkg::ACC_ADD:  acc_q <= sum;
      default:           acc_q <= acc_q;
    endcase
  end

  // lexicographic compare of stored against other
  logic cmp_before, cmp_equal;

  assign cmp_before = (yr_q < oy_q) ||
                      ((yr_q == oy_q) && ((mon_q < om_q) || ((mon_q == om_q) && (day_q < od_q))));
  assign cmp_equal  = (yr_q == oy_q) && (mon_q == om_q) && (day_q == od_q);

  assign sts_o.earlier   = cmp_before;
  assign sts_o.walk_more = carry && (sum != '0);
  assign sts_o.mdec_need = (acc_q != '0) && (day_q < od_q);

  // next stored date
  always_comb begin
    day_d = day_q;
    mon_d = mon_q;
    yr_d  = yr_q;
    ovf_d = ovf_q;
    if (ctl_i.in_load) begin
      ovf_d = 1'b0;
    end else if (ctl_i.walk_adv) begin
      mon_d = adv_mon;
      yr_d  = adv_yr;
      ovf_d = ovf_q | adv_ovf;
    end else if (ctl_i.walk_fin) begin
      day_d = acc_q[cdu_pkg::DAY_W-1:0];
    end else if (ctl_i.simple_exec) begin
      unique case (ctl_i.func)
        cdu_pkg::FUNC_LOAD: begin
          day_d = od_q;
          mon_d = om_q;
          yr_d  = oy_q;
        end
        cdu_pkg::FUNC_NEXT_DAY: begin
          if (day_q >= cur_dim) begin
            day_d = cdu_pkg::FIRST_DAY;
            mon_d = adv_mon;
            yr_d  = adv_yr;
            ovf_d = adv_ovf;
          end else begin
            day_d = day_q + 5'd1;
          end
        end
        cdu_pkg::FUNC_PREV_DAY: begin
          if (day_q <= cdu_pkg::FIRST_DAY) begin
            if (mon_q == cdu_pkg::FIRST_MONTH) begin
              // back over new year into december
              mon_d = cdu_pkg::LAST_MONTH;
              yr_d  = prev_yr;
              ovf_d = (yr_q == '0);
              day_d = cdu_pkg::days_in(cdu_pkg::LAST_MONTH, prev_yr[1:0] == 2'b00);
            end else begin
              mon_d = prev_mon;
              day_d = cdu_pkg::days_in(prev_mon, yr_q[1:0] == 2'b00);
            end
          end else begin
            day_d = day_q - 5'd1;
          end
        end
        cdu_pkg::FUNC_NEXT_MONTH: begin
          mon_d = adv_mon;
          yr_d  = adv_yr;
          ovf_d = adv_ovf;
          day_d = (day_q > adv_dim) ? adv_dim : day_q;
        end
        default: ovf_d = ovf_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      day_q <= cdu_pkg::FIRST_DAY;
      mon_q <= cdu_pkg::FIRST_MONTH;
      yr_q  <= YEAR_BITS'(cdu_pkg::RESET_YEAR);
      ovf_q <= 1'b0;
    end else begin
      day_q <= day_d;
      mon_q <= mon_d;
      yr_q  <= yr_d;
      ovf_q <= ovf_d;
    end
  end

  // result beat
  logic is_day_diff, is_month_diff;

  assign is_day_diff   = (ctl_i.func == cdu_pkg::FUNC_DAY_DIFF);
  assign is_month_diff = (ctl_i.func == cdu_pkg::FUNC_MONTH_DIFF);

  always_ff @(posedge clk_i) begin
    if (ctl_i.out_load) begin
      out_day_q    <= day_q;
      out_mon_q    <= mon_q;
      out_yr_q     <= yr_q;
      out_ovf_q    <= ovf_q;
      out_before_q <= (is_day_diff || is_month_diff) && cmp_before;
      out_equal_q  <= (is_day_diff || is_month_diff) && cmp_equal;
      out_after_q  <= (is_day_diff || is_month_diff) && !cmp_before && !cmp_equal;
      if (is_day_diff) begin
        out_ddiff_q <= cmp_before ? '1 : acc_q[cdu_pkg::DDIFF_W-1:0];
      end else begin
        out_ddiff_q <= '0;
      end
      if (is_month_diff) begin
        out_mdiff_q <= cmp_before ? '1 : acc_q[cdu_pkg::MDIFF_W-1:0];
      end else begin
        out_mdiff_q <= '0;
      end
    end
  end

  assign cur_day_o          = out_day_q;
  assign cur_month_o        = out_mon_q;
  assign cur_year_o         = out_yr_q;
  assign before_other_o     = out_before_q;
  assign equals_other_o     = out_equal_q;
  assign after_other_o      = out_after_q;
  assign day_difference_o   = out_ddiff_q;
  assign month_difference_o = out_mdiff_q;
  assign year_overflow_o    = out_ovf_q;

endmodule

// File: sv/calendar_date_unit_core.sv
// top level of the calendar date unit: sequencer plus shared-adder datapath
// load, next/previous day and next month update the date directly; day
// difference, month difference and add days step through the one adder,
// add days walking the date forward month by month.
// a new beat is taken once the previous one has left the sequencer.
// reset sets the stored date to 1 january of year 2000 and empties the output.
`timescale 1ns / 1ps

module calendar_date_unit_core #(
  parameter int YEAR_BITS  = 12,
  parameter int COUNT_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [2:0]                         func_i,
  input  logic [COUNT_BITS-1:0]              day_count_i,
  input  logic [cdu_pkg::DAY_W-1:0]          other_day_i,
  input  logic [cdu_pkg::MON_W-1:0]          other_month_i,
  input  logic [YEAR_BITS-1:0]               other_year_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [cdu_pkg::DAY_W-1:0]          cur_day_o,
  output logic [cdu_pkg::MON_W-1:0]          cur_month_o,
  output logic [YEAR_BITS-1:0]               cur_year_o,
  output logic                               before_other_o,
  output logic                               equals_other_o,
  output logic                               after_other_o,
  output logic signed [cdu_pkg::DDIFF_W-1:0] day_difference_o,
  output logic signed [cdu_pkg::MDIFF_W-1:0] month_difference_o,
  output logic                               year_overflow_o
);

  cdu_pkg::ctl_t ctl;
  cdu_pkg::sts_t sts;

  // sequencer
  cdu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .func_i      (func_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .ctl_o       (ctl)
  );

  // datapath
  cdu_datapath #(
    .YEAR_BITS  (YEAR_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .ctl_i              (ctl),
    .sts_o              (sts),
    .day_count_i        (day_count_i),
    .other_day_i        (other_day_i),
    .other_month_i      (other_month_i),
    .other_year_i       (other_year_i),
    .cur_day_o          (cur_day_o),
    .cur_month_o        (cur_month_o),
    .cur_year_o         (cur_year_o),
    .before_other_o     (before_other_o),
    .equals_other_o     (equals_other_o),
    .after_other_o      (after_other_o),
    .day_difference_o   (day_difference_o),
    .month_difference_o (month_difference_o),
    .year_overflow_o    (year_overflow_o)
  );

endmodule
